FILE: hdl/upd_pkg.sv
// shared types, constants and hex helpers for the url percent decoder
`default_nettype none
package upd_pkg;

  localparam int unsigned CntW = 16;
  localparam int unsigned MaxRes = 4;
  localparam int unsigned ResCntW = 3;

  localparam logic [7:0] PctChar = 8'h25;
  localparam logic [7:0] PlusChar = 8'h2B;
  localparam logic [7:0] SpaceChar = 8'h20;
  localparam logic [7:0] CaseDelta = 8'h20;
  localparam logic [7:0] AlphaBase = 8'h41 - 8'd10;
  localparam logic [7:0] DigitBase = 8'h30;
  localparam logic [CntW-1:0] LimitReset = '1;

  localparam logic [1:0] PendNone = 2'd0;
  localparam logic [1:0] PendPct = 2'd1;
  localparam logic [1:0] PendDigit = 2'd2;

  typedef struct packed {
    logic [1:0]      pending;
    logic [7:0]      held;
    logic [CntW-1:0] emitted;
    logic            truncated;
  } upd_state_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_string;
  } upd_res_t;

  typedef upd_res_t [MaxRes-1:0] upd_res_vec_t;

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
             (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] u;
    u = c;
    if (c >= 8'h61 && c <= 8'h66) begin
      u = c - CaseDelta;
    end
    if (u <= 8'h39) begin
      hex_val = 4'(u - DigitBase);
    end else begin
      hex_val = 4'(u - AlphaBase);
    end
  endfunction

endpackage
`default_nettype wire

FILE: hdl/upd_intf.sv
// channel interfaces: encoded byte input, decoded result output, limit write
`default_nettype none
interface upd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;
  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface upd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       end_of_string;
  modport source (output valid, output out_byte, output end_of_string, input ready);
  modport sink (input valid, input out_byte, input end_of_string, output ready);
endinterface

interface upd_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [upd_pkg::CntW-1:0]  out_limit;
  modport source (output valid, output out_limit, input ready);
  modport sink (input valid, input out_limit, output ready);
endinterface
`default_nettype wire

FILE: hdl/url_percent_decoder.sv
// top level: streaming form-urlencoded decoder with output length limit
//
//  channel   dir  payload                       request
//  in_ch_i   in   in_byte[7:0], in_last         one encoded byte
//  out_ch_o  out  out_byte[7:0], end_of_string  one decoded byte or terminator
//  cfg_ch_i  in   out_limit[15:0]               limit write, always ready
//
// one byte per cycle while the output is ready and each byte yields at most
// one result; a byte that yields up to four results holds the input until
// the four-entry result buffer, draining one entry per ready cycle, empties.
// an input register takes a byte while a result is still waiting.
// reset clears the decode state and sets the limit to 65535.
`default_nettype none
module url_percent_decoder (
  input  logic      clk_i,
  input  logic      rst_ni,
  upd_in_if.sink    in_ch_i,
  upd_out_if.source out_ch_o,
  upd_cfg_if.sink   cfg_ch_i
);

  logic                           inq_v_q;
  logic [7:0]                     inq_byte_q;
  logic                           inq_last_q;
  upd_pkg::upd_state_t            state_q;
  upd_pkg::upd_state_t            state_d;
  upd_pkg::upd_res_vec_t          res_q;
  upd_pkg::upd_res_vec_t          res_d;
  logic [upd_pkg::ResCntW-1:0]    cnt_q;
  logic [upd_pkg::ResCntW-1:0]    cnt_d;
  logic [upd_pkg::CntW-1:0]       limit_q;
  logic                           pop;
  logic                           load;
  logic                           in_acc;

  upd_step u_step (
    .state_i   (state_q),
    .byte_i    (inq_byte_q),
    .last_i    (inq_last_q),
    .limit_i   (limit_q),
    .state_o   (state_d),
    .res_o     (res_d),
    .res_cnt_o (cnt_d)
  );

  assign pop = out_ch_o.valid && out_ch_o.ready;
  // buffer takes a new set when empty or as its last entry leaves
  assign load = inq_v_q && ((cnt_q == '0) || (cnt_q == upd_pkg::ResCntW'(1) && pop));
  assign in_ch_i.ready = !inq_v_q || load;
  assign in_acc = in_ch_i.valid && in_ch_i.ready;

  assign out_ch_o.valid = (cnt_q != '0);
  assign out_ch_o.out_byte = res_q[0].out_byte;
  assign out_ch_o.end_of_string = res_q[0].end_of_string;
  assign cfg_ch_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_v_q <= 1'b0;
      state_q <= '0;
      cnt_q <= '0;
      limit_q <= upd_pkg::LimitReset;
    end else begin
      if (in_acc) begin
        inq_v_q <= 1'b1;
      end else if (load) begin
        inq_v_q <= 1'b0;
      end
      if (load) begin
        state_q <= state_d;
        cnt_q <= cnt_d;
      end else if (pop) begin
        cnt_q <= cnt_q - 1'b1;
      end
      if (cfg_ch_i.valid) begin
        limit_q <= cfg_ch_i.out_limit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      inq_byte_q <= in_ch_i.in_byte;
      inq_last_q <= in_ch_i.in_last;
    end
    if (load) begin
      res_q <= res_d;
    end else if (pop) begin
      for (int i = 0; i < upd_pkg::MaxRes - 1; i++) begin
        res_q[i] <= res_q[i+1];
      end
      res_q[upd_pkg::MaxRes-1] <= '0;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/upd_step.sv
// decode step: results and next state for one encoded byte
`default_nettype none
module upd_step (
  input  upd_pkg::upd_state_t           state_i,
  input  logic [7:0]                    byte_i,
  input  logic                          last_i,
  input  logic [upd_pkg::CntW-1:0]      limit_i,
  output upd_pkg::upd_state_t           state_o,
  output upd_pkg::upd_res_vec_t         res_o,
  output logic [upd_pkg::ResCntW-1:0]   res_cnt_o
);

  logic [upd_pkg::MaxRes-1:0][7:0] emit;
  logic [upd_pkg::ResCntW-1:0]     n;
  logic [upd_pkg::ResCntW-1:0]     k;
  logic [1:0]                      pend;
  logic [7:0]                      held;
  logic                            fin;
  logic                            do_plain;
  logic                            hit;
  logic                            over;
  logic [upd_pkg::CntW-1:0]        lim;
  logic [upd_pkg::CntW-1:0]        rem;

  assign fin = (byte_i == 8'h00) || last_i;

  // candidate emits in order, before the limit is applied
  always_comb begin
    emit = '0;
    n = '0;
    pend = state_i.pending;
    held = state_i.held;
    do_plain = 1'b0;
    if (!state_i.truncated && byte_i != 8'h00) begin
      case (state_i.pending)
        upd_pkg::PendPct: begin
          if (upd_pkg::is_hex(byte_i)) begin
            held = byte_i;
            pend = upd_pkg::PendDigit;
          end else begin
            pend = upd_pkg::PendNone;
            emit[n[1:0]] = upd_pkg::PctChar;
            n = n + 1'b1;
            do_plain = 1'b1;
          end
        end
        upd_pkg::PendDigit: begin
          pend = upd_pkg::PendNone;
          held = '0;
          if (upd_pkg::is_hex(byte_i)) begin
            emit[n[1:0]] = {upd_pkg::hex_val(state_i.held), upd_pkg::hex_val(byte_i)};
            n = n + 1'b1;
          end else begin
            // held digit is never '%' or '+', so it goes out as is
            emit[n[1:0]] = upd_pkg::PctChar;
            emit[1] = state_i.held;
            n = 3'd2;
            do_plain = 1'b1;
          end
        end
        default: begin
          pend = upd_pkg::PendNone;
          do_plain = 1'b1;
        end
      endcase
      if (do_plain) begin
        if (byte_i == upd_pkg::PctChar) begin
          pend = upd_pkg::PendPct;
        end else begin
          emit[n[1:0]] = (byte_i == upd_pkg::PlusChar) ? upd_pkg::SpaceChar : byte_i;
          n = n + 1'b1;
        end
      end
    end
    // flush held bytes literally at end of string
    if (fin && !state_i.truncated) begin
      if (pend == upd_pkg::PendPct) begin
        emit[n[1:0]] = upd_pkg::PctChar;
        n = n + 1'b1;
      end else if (pend == upd_pkg::PendDigit) begin
        emit[n[1:0]] = upd_pkg::PctChar;
        emit[2'(n + 1'b1)] = held;
        n = n + 3'd2;
      end
    end
  end

  assign lim = (limit_i == '0) ? upd_pkg::CntW'(1) : limit_i;
  assign rem = lim - state_i.emitted;
  // limit lowered below the count mid-string: the next byte still goes out
  assign over = (state_i.emitted >= lim);
  assign hit = !state_i.truncated && (n != '0) &&
               (over || (upd_pkg::CntW'(n) >= rem));
  assign k = !hit ? n :
             over ? upd_pkg::ResCntW'(1) : rem[upd_pkg::ResCntW-1:0];

  always_comb begin
    res_o = '0;
    for (int i = 0; i < upd_pkg::MaxRes; i++) begin
      if (upd_pkg::ResCntW'(i) < k) begin
        res_o[i].out_byte = emit[i];
      end
    end
    res_cnt_o = k;
    if (fin && k != upd_pkg::ResCntW'(upd_pkg::MaxRes)) begin
      res_o[k[1:0]].out_byte = 8'h00;
      res_o[k[1:0]].end_of_string = 1'b1;
      res_cnt_o = k + 1'b1;
    end
  end

  always_comb begin
    if (fin) begin
      state_o = '0;
    end else if (hit) begin
      state_o.pending = upd_pkg::PendNone;
      state_o.held = '0;
      state_o.emitted = state_i.emitted + upd_pkg::CntW'(k);
      state_o.truncated = 1'b1;
    end else begin
      state_o.pending = pend;
      state_o.held = held;
      state_o.emitted = state_i.emitted + upd_pkg::CntW'(k);
      state_o.truncated = state_i.truncated;
    end
  end

endmodule
`default_nettype wire
